[rtl/srp_pkg.sv]
package srp_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int COORD_BITS_DEF   = 13;

	localparam int DIM_W    = 13;
	localparam int POS_W    = 12;
	localparam int AREA_W   = 25;
	localparam int STATUS_W = 2;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_ATLAS_WIDTH  = 2'd0,
		REG_ATLAS_HEIGHT = 2'd1
	} reg_idx_t;

endpackage

[rtl/srp_ram.sv]
module srp_ram #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/skyline_rect_packer.sv]
// Skyline bottom-left packer. A request (start while busy is low) places one rectangle; the
// single result appears on status/pos_x/pos_y/area_used for exactly one cycle with done high
// and cannot be held off. The skyline lives in one RAM with one read and one write port, so a
// request reads the segments one at a time while testing each start segment (each test
// walks the segments the rectangle would cover), then reads the neighbours, and moves the
// segments one at a time when the list is rewritten, before writing the new head segment.
// Requests with a zero or oversized dimension are answered from idle without a search. After
// reset and after every atlas width or height write the packer lays down the floor segment.
module skyline_rect_packer #(
	parameter int MAX_SEGMENTS = srp_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = srp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [srp_pkg::DIM_W-1:0]     rect_width,
	input  logic [srp_pkg::DIM_W-1:0]     rect_height,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [srp_pkg::DIM_W-1:0]     cfg_data,
	output logic                          done,
	output logic [srp_pkg::STATUS_W-1:0]  status,
	output logic [srp_pkg::POS_W-1:0]     pos_x,
	output logic [srp_pkg::POS_W-1:0]     pos_y,
	output logic [srp_pkg::AREA_W-1:0]    area_used
);
	import srp_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AW  = ((CB > DIM_W) ? CB : DIM_W) + 2;
	localparam int IW  = $clog2(MAX_SEGMENTS);
	localparam int CNW = $clog2(MAX_SEGMENTS + 1);
	localparam int NW  = $clog2(MAX_SEGMENTS + 2);
	localparam int NX  = NW + 1;
	localparam int MW  = 3 * CB;
	localparam logic [AW-1:0] ATLAS_MAX = AW'(1) << (CB - 1);
	localparam logic [NX-1:0] MAX_N = NX'(MAX_SEGMENTS);

	typedef enum logic [16:0] {
		S_INIT = 17'b1 << 0,
		S_IDLE = 17'b1 << 1,
		S_C_RD = 17'b1 << 2,
		S_C_EV = 17'b1 << 3,
		S_J_RD = 17'b1 << 4,
		S_J_EV = 17'b1 << 5,
		S_POST = 17'b1 << 6,
		S_P_RD = 17'b1 << 7,
		S_P_EV = 17'b1 << 8,
		S_K_RD = 17'b1 << 9,
		S_K_EV = 17'b1 << 10,
		S_CALC = 17'b1 << 11,
		S_M_RD = 17'b1 << 12,
		S_M_WR = 17'b1 << 13,
		S_HEAD = 17'b1 << 14,
		S_TRIM = 17'b1 << 15,
		S_FIN  = 17'b1 << 16
	} state_t;

	function automatic logic [AW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [AW-1:0] e;
		e = AW'(v);
		if (e == '0) begin
			return AW'(1);
		end
		if (e > ATLAS_MAX) begin
			return ATLAS_MAX;
		end
		return e;
	endfunction

	function automatic logic [AW-1:0] ext(input logic [CB-1:0] v);
		return AW'(v);
	endfunction

	state_t              st_q;
	logic [DIM_W-1:0]    aw_reg_q, ah_reg_q;
	logic [AW-1:0]       w_q, h_q, rem_q, y_q, cleft_q, cspan_q;
	logic [AW-1:0]       by_q, bw_q, bx_q;
	logic [AW-1:0]       ptop_q, pleft_q, pspan_q, ktop_q, kleft_q, kspan_q;
	logic [2*DIM_W-1:0]  prod_q;
	logic [AREA_W-1:0]   area_q;
	logic [CNW-1:0]      cnt_q, i_q, j_q, bi_q, blast_q, p_q, s_q;
	logic                found_q, bexact_q, mp_q, mn_q;
	logic [NX-1:0]       n_q, delta_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    px_q, py_q;
	logic [AREA_W-1:0]   aout_q;

	logic [AW-1:0]  aw_c, ah_c, rd_left, rd_top, rd_span;
	logic [AW-1:0]  ynew, rem_in, cand_span, cand_left, nt, bxw, kend, head_span;
	logic [AW-1:0]  in_w, in_h;
	logic           hfail, covered, exact_c, better, over_c, jfail;
	logic [CNW-1:0] cur_last, next_j, k_c;
	logic           has_k, mp_c, mn_c, in_bad;
	logic [CNW-1:0] p_c;
	logic [NX-1:0]  n_c, delta_c, dest_c;
	logic [AREA_W+1:0] area_sum;

	logic           we;
	logic [IW-1:0]  waddr, raddr;
	logic [MW-1:0]  wdata, rdata;

	srp_ram #(.WIDTH(MW), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign aw_c    = clamp_dim(aw_reg_q);
	assign ah_c    = clamp_dim(ah_reg_q);
	assign in_w    = AW'(rect_width);
	assign in_h    = AW'(rect_height);
	assign in_bad  = (in_w == '0) || (in_h == '0) || (in_w > aw_c) || (in_h > ah_c);
	assign rd_left = ext(rdata[3*CB-1:2*CB]);
	assign rd_top  = ext(rdata[2*CB-1:CB]);
	assign rd_span = ext(rdata[CB-1:0]);

	always_comb begin
		if (st_q == S_C_EV) begin
			ynew      = rd_top;
			rem_in    = w_q;
			cand_span = rd_span;
			cand_left = rd_left;
			cur_last  = i_q;
		end else begin
			ynew      = (rd_top > y_q) ? rd_top : y_q;
			rem_in    = rem_q;
			cand_span = cspan_q;
			cand_left = cleft_q;
			cur_last  = j_q;
		end
	end

	assign over_c   = (rd_left + w_q) > aw_c;
	assign hfail    = (ynew + h_q) > ah_c;
	assign covered  = rd_span >= rem_in;
	assign exact_c  = rd_span == rem_in;
	assign better   = (ynew < by_q) || ((ynew == by_q) && (cand_span < bw_q));
	assign next_j   = cur_last + CNW'(1);
	assign jfail    = next_j >= cnt_q;

	assign k_c       = bexact_q ? (blast_q + CNW'(1)) : blast_q;
	assign has_k     = k_c < cnt_q;
	assign nt        = by_q + h_q;
	assign bxw       = bx_q + w_q;
	assign kend      = kleft_q + kspan_q;
	assign mp_c      = (bi_q != '0) && (ptop_q == nt);
	assign mn_c      = has_k && (ktop_q == nt);
	assign p_c       = mp_c ? (bi_q - CNW'(1)) : bi_q;
	assign n_c       = NX'(bi_q) + NX'(1) + NX'(cnt_q) - NX'(k_c) - NX'(mp_c) - NX'(mn_c);
	assign delta_c   = NX'(p_c) + NX'(1) - NX'(k_c) - NX'(mn_c);
	assign dest_c    = NX'(s_q) + delta_q;
	assign head_span = (mp_q ? pspan_q : '0) + w_q + (mn_q ? (kend - bxw) : '0);
	assign area_sum  = (AREA_W+2)'(area_q) + (AREA_W+2)'(prod_q);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (st_q)
			S_INIT: begin
				we    = 1'b1;
				wdata = {CB'(0), CB'(0), aw_c[CB-1:0]};
			end
			S_C_RD: raddr = i_q[IW-1:0];
			S_J_RD: raddr = j_q[IW-1:0];
			S_P_RD: raddr = IW'(bi_q - CNW'(1));
			S_K_RD: raddr = k_c[IW-1:0];
			S_M_RD: raddr = s_q[IW-1:0];
			S_M_WR: begin
				we    = 1'b1;
				waddr = dest_c[IW-1:0];
				wdata = rdata;
			end
			S_HEAD: begin
				we    = 1'b1;
				waddr = p_q[IW-1:0];
				wdata = {(mp_q ? pleft_q[CB-1:0] : bx_q[CB-1:0]), nt[CB-1:0],
					head_span[CB-1:0]};
			end
			S_TRIM: begin
				we    = 1'b1;
				waddr = IW'(p_q + CNW'(1));
				wdata = {bxw[CB-1:0], ktop_q[CB-1:0], kend[CB-1:0] - bxw[CB-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_INIT;
			aw_reg_q <= DIM_W'(4096);
			ah_reg_q <= DIM_W'(4096);
			cnt_q    <= CNW'(1);
			area_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we && (cfg_index == REG_ATLAS_WIDTH || cfg_index == REG_ATLAS_HEIGHT)) begin
				if (cfg_index == REG_ATLAS_WIDTH) begin
					aw_reg_q <= cfg_data;
				end else begin
					ah_reg_q <= cfg_data;
				end
				st_q <= S_INIT;
			end else begin
				unique case (st_q)
					S_INIT: begin
						cnt_q  <= CNW'(1);
						area_q <= '0;
						st_q   <= S_IDLE;
					end
					S_IDLE: begin
						if (start) begin
							if (in_bad) begin
								done_q   <= 1'b1;
								status_q <= ST_NO_FIT;
								px_q     <= '0;
								py_q     <= '0;
								aout_q   <= area_q;
							end else begin
								w_q     <= in_w;
								h_q     <= in_h;
								prod_q  <= rect_width * rect_height;
								by_q    <= ah_c + AW'(1);
								bw_q    <= aw_c + AW'(1);
								found_q <= 1'b0;
								i_q     <= '0;
								st_q    <= S_C_RD;
							end
						end
					end
					S_C_RD, S_J_RD: st_q <= (st_q == S_C_RD) ? S_C_EV : S_J_EV;
					S_C_EV, S_J_EV: begin
						if (st_q == S_C_EV) begin
							cleft_q <= rd_left;
							cspan_q <= rd_span;
						end
						y_q <= ynew;
						if ((st_q == S_C_EV && over_c) || hfail) begin
							i_q  <= i_q + CNW'(1);
							st_q <= ((i_q + CNW'(1)) >= cnt_q) ? S_POST : S_C_RD;
						end else if (covered) begin
							if (better) begin
								found_q  <= 1'b1;
								bi_q     <= i_q;
								by_q     <= ynew;
								bw_q     <= cand_span;
								bx_q     <= cand_left;
								blast_q  <= cur_last;
								bexact_q <= exact_c;
							end
							i_q  <= i_q + CNW'(1);
							st_q <= ((i_q + CNW'(1)) >= cnt_q) ? S_POST : S_C_RD;
						end else if (jfail) begin
							i_q  <= i_q + CNW'(1);
							st_q <= ((i_q + CNW'(1)) >= cnt_q) ? S_POST : S_C_RD;
						end else begin
							rem_q <= rem_in - rd_span;
							j_q   <= next_j;
							st_q  <= S_J_RD;
						end
					end
					S_POST: begin
						if (!found_q) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_FIT;
							px_q     <= '0;
							py_q     <= '0;
							aout_q   <= area_q;
							st_q     <= S_IDLE;
						end else begin
							ptop_q <= '0;
							st_q   <= (bi_q != '0) ? S_P_RD : S_K_RD;
						end
					end
					S_P_RD: st_q <= S_P_EV;
					S_P_EV: begin
						ptop_q  <= rd_top;
						pleft_q <= rd_left;
						pspan_q <= rd_span;
						st_q    <= S_K_RD;
					end
					S_K_RD: st_q <= S_K_EV;
					S_K_EV: begin
						ktop_q  <= rd_top;
						kleft_q <= rd_left;
						kspan_q <= rd_span;
						st_q    <= S_CALC;
					end
					S_CALC: begin
						mp_q    <= mp_c;
						mn_q    <= mn_c;
						p_q     <= p_c;
						n_q     <= n_c;
						delta_q <= delta_c;
						if (n_c > MAX_N) begin
							done_q   <= 1'b1;
							status_q <= ST_FULL;
							px_q     <= '0;
							py_q     <= '0;
							aout_q   <= area_q;
							st_q     <= S_IDLE;
						end else if (delta_c == '0 || (k_c + CNW'(1)) >= cnt_q) begin
							st_q <= S_HEAD;
						end else begin
							s_q  <= $signed(delta_c) > 0 ? (cnt_q - CNW'(1)) : (k_c + CNW'(1));
							st_q <= S_M_RD;
						end
					end
					S_M_RD: st_q <= S_M_WR;
					S_M_WR: begin
						if ($signed(delta_q) > 0) begin
							if (s_q == k_c + CNW'(1)) begin
								st_q <= S_HEAD;
							end else begin
								s_q  <= s_q - CNW'(1);
								st_q <= S_M_RD;
							end
						end else begin
							if (s_q == cnt_q - CNW'(1)) begin
								st_q <= S_HEAD;
							end else begin
								s_q  <= s_q + CNW'(1);
								st_q <= S_M_RD;
							end
						end
					end
					S_HEAD: st_q <= (has_k && !mn_q) ? S_TRIM : S_FIN;
					S_TRIM: st_q <= S_FIN;
					S_FIN: begin
						cnt_q    <= n_q[CNW-1:0];
						area_q   <= (area_sum > (AREA_W+2)'(AREA_MAX)) ? AREA_MAX
							: area_sum[AREA_W-1:0];
						aout_q   <= (area_sum > (AREA_W+2)'(AREA_MAX)) ? AREA_MAX
							: area_sum[AREA_W-1:0];
						done_q   <= 1'b1;
						status_q <= ST_PLACED;
						px_q     <= bx_q[POS_W-1:0];
						py_q     <= by_q[POS_W-1:0];
						st_q     <= S_IDLE;
					end
					default: st_q <= S_INIT;
				endcase
			end
		end
	end

	assign busy      = (st_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign pos_x     = px_q;
	assign pos_y     = py_q;
	assign area_used = aout_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> st_q == S_IDLE) else $error("result shown while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CNW'(MAX_SEGMENTS))) else $error("segment count out of range");
	a_accept_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy || done_q)) else $error("request dropped");
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> st_q != S_IDLE) else $error("skyline written while idle");
`endif

endmodule
